[hdl/nlq_pkg.sv]
// ----------------------------------------------------------------------------
// nlq_pkg
// Shared constants and types for the nearest level quantiser: table depth,
// field widths, operation and status codes, the link between cells and the broadcast item.
// ----------------------------------------------------------------------------
package nlq_pkg;

  localparam int MAX_LEVELS = 16;
  localparam int CNT_W      = $clog2(MAX_LEVELS + 1);
  localparam int KEY_W      = 32;
  localparam int LVL_W      = 32;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;
  localparam int ENTRIES_W  = 5;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Data handed from one cell to its right-hand neighbour.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [LVL_W-1:0]        level;
    logic                    le_key;  // held key is valid and <= incoming key
  } nlq_link_t;

  // Item broadcast to every cell of the row.
  typedef struct packed {
    logic                    load_en;
    logic signed [KEY_W-1:0] key;
    logic [LVL_W-1:0]        level;
  } nlq_bcast_t;

endpackage

[hdl/nlq_cell.sv]
// ----------------------------------------------------------------------------
// nlq_cell
// One entry of the sorted table. Holds a key and its level, decides locally
// whether to keep, take the new pair or take its left neighbour's pair on a
// load, and tests the midpoint with its left neighbour on a query.
// ----------------------------------------------------------------------------
module nlq_cell (
  input  logic                     clk,
  input  logic                     head,      // first cell of the row
  input  logic                     valid,     // entry lies below the fill count
  input  nlq_pkg::nlq_bcast_t      bcast,
  input  nlq_pkg::nlq_link_t       link_in,
  input  logic                     gt_right,  // query lies above right midpoint
  output nlq_pkg::nlq_link_t       link_out,
  output logic                     gt_left,   // query lies above left midpoint
  output logic [nlq_pkg::LVL_W-1:0] sel_level
);
  import nlq_pkg::*;

  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [LVL_W-1:0]        level_r, level_nxt;
  logic                    le_key;
  logic signed [KEY_W+1:0] twice;
  logic signed [KEY_W+1:0] pair_sum;

  assign le_key = valid && (key_r <= bcast.key);

  assign link_out.key    = key_r;
  assign link_out.level  = level_r;
  assign link_out.le_key = le_key;

  // The midpoint test 2x > a+b is exact in two extra bits.
  assign twice    = {bcast.key[KEY_W-1], bcast.key, 1'b0};
  assign pair_sum = {{2{link_in.key[KEY_W-1]}}, link_in.key}
                  + {{2{key_r[KEY_W-1]}}, key_r};
  assign gt_left  = valid && !head && (twice > pair_sum);

  // Midpoint flags form a prefix of ones, so exactly one valid cell is the head or
  // sees a raised flag on its left, and sees a clear one on its right.
  assign sel_level = (valid && (head || gt_left) && !gt_right) ? level_r : '0;

  always_comb begin
    key_nxt   = key_r;
    level_nxt = level_r;
    if (bcast.load_en && !le_key) begin
      if (head || link_in.le_key) begin
        key_nxt   = bcast.key;
        level_nxt = bcast.level;
      end else begin
        key_nxt   = link_in.key;
        level_nxt = link_in.level;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    level_r <= level_nxt;
  end

endmodule

[hdl/nearest_level_quantizer.sv]
// ----------------------------------------------------------------------------
// nearest_level_quantizer
// Sorted table of (key, level) pairs held in a row of cells. Loads insert in
// key order, queries return the level of the nearest key, clears empty it.
// ----------------------------------------------------------------------------
// The result strobe rises in the cycle after the start transfer.
// Throughput: one item per cycle; busy never rises, as every cell of the row
// inserts or compares within the same cycle.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset empties the table by clearing the fill count; cell contents persist.
module nearest_level_quantizer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [nlq_pkg::OP_W-1:0]    in_opcode,
  input  logic signed [nlq_pkg::KEY_W-1:0] in_key,
  input  logic signed [nlq_pkg::LVL_W-1:0] in_level,
  output logic                        out_strobe,
  output logic signed [nlq_pkg::LVL_W-1:0] out_value,
  output logic [nlq_pkg::STAT_W-1:0]  out_status,
  output logic [nlq_pkg::ENTRIES_W-1:0] out_entries
);
  import nlq_pkg::*;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 strobe_r;
  logic [LVL_W-1:0]     value_r, value_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic [ENTRIES_W-1:0] entries_r;

  logic                 accept;
  logic                 full;
  logic                 load_ok;
  nlq_bcast_t           bcast;
  logic [MAX_LEVELS-1:0] valid;
  logic [MAX_LEVELS:0]   gt;
  nlq_link_t            link [MAX_LEVELS+1];
  logic [LVL_W-1:0]     sel [MAX_LEVELS];
  logic [LVL_W-1:0]     sel_any;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign full    = (count_r == CNT_W'(MAX_LEVELS));
  assign load_ok = accept && (in_opcode == OP_LOAD) && !full;

  assign bcast.load_en = load_ok;
  assign bcast.key     = in_key;
  assign bcast.level   = in_level;

  assign link[0] = '0;
  assign gt[MAX_LEVELS] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_LEVELS; gi++) begin : g_cell
      assign valid[gi] = (CNT_W'(gi) < count_r);
      nlq_cell u_cell (
        .clk       (clk),
        .head      ((gi == 0) ? 1'b1 : 1'b0),
        .valid     (valid[gi]),
        .bcast     (bcast),
        .link_in   (link[gi]),
        .gt_right  (gt[gi+1]),
        .link_out  (link[gi+1]),
        .gt_left   (gt[gi]),
        .sel_level (sel[gi])
      );
    end
  endgenerate

  always_comb begin
    sel_any = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      sel_any = sel_any | sel[i];
    end
  end

  always_comb begin
    count_nxt  = count_r;
    value_nxt  = '0;
    status_nxt = ST_OK;
    case (in_opcode)
      OP_LOAD: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_QUERY: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          value_nxt = sel_any;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r   <= value_nxt;
      status_r  <= status_nxt;
      entries_r <= ENTRIES_W'(count_nxt);
    end
  end

  assign out_strobe  = strobe_r;
  assign out_value   = value_r;
  assign out_status  = status_r;
  assign out_entries = entries_r;

endmodule

[bench/tb_nearest_level_quantizer.sv]
// ----------------------------------------------------------------------------
// tb_nearest_level_quantizer
// Self-checking bench for the nearest level quantiser. A directed part covers
// the empty table, the unused opcode, the extreme keys and levels, equal keys,
// exact midpoints and a full table. A long random part follows, made mostly of
// load and query runs with occasional clears. Each result is checked against
// the bench's own copy of the sorted table.
// ----------------------------------------------------------------------------
module tb_nearest_level_quantizer;
  timeunit 1ns;
  timeprecision 1ps;

  import nlq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1500;
  localparam int STALL_LIMIT  = 500;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [LVL_W-1:0]        level_t;

  typedef struct {
    level_t                value;
    logic [STAT_W-1:0]     status;
    logic [ENTRIES_W-1:0]  entries;
  } lookup_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_opcode = OP_UNUSED;
  key_t                 in_key = '0;
  logic signed [LVL_W-1:0] in_level = '0;
  logic                 out_strobe;
  logic signed [LVL_W-1:0] out_value;
  logic [STAT_W-1:0]    out_status;
  logic [ENTRIES_W-1:0] out_entries;

  // Shadow copy of the sorted table.
  key_t   shadow_keys [MAX_LEVELS];
  level_t shadow_levels [MAX_LEVELS];
  int     shadow_count = 0;

  lookup_result_t due_results[$];
  int fault_count = 0;

  nearest_level_quantizer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_opcode   (in_opcode),
    .in_key      (in_key),
    .in_level    (in_level),
    .out_strobe  (out_strobe),
    .out_value   (out_value),
    .out_status  (out_status),
    .out_entries (out_entries)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one accepted item to the shadow table and queues its result.
  task automatic quantise_item(input logic [OP_W-1:0] op, input key_t key,
                               input level_t lvl);
    lookup_result_t res;
    int pos;
    int idx;
    longint twice;
    longint pair_sum;
    res.value  = '0;
    res.status = ST_OK;
    if (op == OP_LOAD) begin
      if (shadow_count >= MAX_LEVELS) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] <= key) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_keys[i]   = shadow_keys[i-1];
          shadow_levels[i] = shadow_levels[i-1];
        end
        shadow_keys[pos]   = key;
        shadow_levels[pos] = lvl;
        shadow_count++;
      end
    end else if (op == OP_QUERY) begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        // Count the midpoints strictly below the query, compared as 2x > a+b.
        idx   = 0;
        twice = longint'(key) * 2;
        for (int i = 0; i + 1 < shadow_count; i++) begin
          pair_sum = longint'(shadow_keys[i]) + longint'(shadow_keys[i+1]);
          if (twice > pair_sum) idx++;
        end
        if (idx >= shadow_count) idx = shadow_count - 1;
        res.value = shadow_levels[idx];
      end
    end else if (op == OP_CLEAR) begin
      shadow_count = 0;
    end
    res.entries = ENTRIES_W'(shadow_count);
    due_results.push_back(res);
  endtask

  // Offers one item and holds it until the transfer takes place.
  task automatic send_item(input logic [OP_W-1:0] op, input key_t key,
                           input level_t lvl);
    @(negedge clk);
    start     <= 1'b1;
    in_opcode <= op;
    in_key    <= key;
    in_level  <= lvl;
    do @(posedge clk); while (busy !== 1'b0);
    quantise_item(op, key, lvl);
  endtask

  // Idle cycles with start low; the payload ports carry noise meanwhile.
  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start     <= 1'b0;
      in_opcode <= OP_W'($urandom);
      in_key    <= key_t'($urandom);
      in_level  <= LVL_W'($urandom);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic key_t pick_extreme();
    case ($urandom_range(4))
      0: return key_t'(32'h8000_0000);
      1: return key_t'(32'h7fff_ffff);
      2: return key_t'(0);
      3: return key_t'(-1);
      default: return key_t'(1);
    endcase
  endfunction

  function automatic key_t pick_grid();
    return key_t'((int'($urandom_range(16)) - 8) <<< 16);
  endfunction

  function automatic key_t pick_load_key();
    int r;
    r = $urandom_range(99);
    if (r < 30) return key_t'($urandom);
    if (r < 70) return pick_grid();
    if (r < 85 && shadow_count > 0)
      return shadow_keys[$urandom_range(shadow_count - 1)];
    return pick_extreme();
  endfunction

  function automatic key_t pick_query_key();
    int r;
    int i;
    longint mid;
    r = $urandom_range(99);
    if (r < 25) return key_t'($urandom);
    if (r < 50) return pick_grid();
    if (r < 85 && shadow_count >= 2) begin
      // Land on, just below or just above a midpoint.
      i   = $urandom_range(shadow_count - 2);
      mid = (longint'(shadow_keys[i]) + longint'(shadow_keys[i+1])) >>> 1;
      return key_t'(mid + longint'($urandom_range(2)) - 1);
    end
    if (r < 92 && shadow_count > 0)
      return shadow_keys[$urandom_range(shadow_count - 1)];
    return pick_extreme();
  endfunction

  // Result checker: every strobe must match the oldest queued expectation.
  always @(posedge clk) begin
    lookup_result_t exp_res;
    if (rst_n && out_strobe === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("result transfer with no item outstanding");
        fault_count++;
      end else begin
        exp_res = due_results.pop_front();
        if (out_value !== exp_res.value) begin
          $error("value: expected %h, actual %h", exp_res.value, out_value);
          fault_count++;
        end
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_status);
          fault_count++;
        end
        if (out_entries !== exp_res.entries) begin
          $error("entries: expected %0d, actual %0d", exp_res.entries, out_entries);
          fault_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no transfer happens on either side.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || out_strobe === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL nearest_level_quantizer");
    $finish;
  end

  task automatic test_empty_and_unused();
    send_item(OP_QUERY, key_t'(0), '0);
    send_item(OP_CLEAR, key_t'(32'h1234_5678), level_t'(32'hdead_beef));
    send_item(OP_UNUSED, key_t'(32'h7fff_ffff), level_t'(32'hffff_ffff));
  endtask

  task automatic test_extremes();
    send_item(OP_LOAD, key_t'(32'h7fff_ffff), level_t'(32'h8000_0000));
    // A single entry answers every query.
    send_item(OP_QUERY, key_t'(32'h8000_0000), '0);
    send_item(OP_LOAD, key_t'(32'h8000_0000), level_t'(32'h7fff_ffff));
    send_item(OP_QUERY, key_t'(0), '0);
    send_item(OP_QUERY, key_t'(-1), '0);
    // An equal key is placed after the one already held.
    send_item(OP_LOAD, key_t'(32'h7fff_ffff), level_t'(32'hffff_ffff));
    send_item(OP_QUERY, key_t'(32'h7fff_ffff), '0);
    send_item(OP_UNUSED, key_t'(5), level_t'(7));
    send_item(OP_QUERY, key_t'(32'h8000_0000), '0);
  endtask

  task automatic test_ties_and_midpoints();
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_LOAD, key_t'(0), level_t'(1));
    send_item(OP_LOAD, key_t'(10 <<< 16), level_t'(2));
    // A query exactly on a midpoint resolves to the lower neighbour.
    send_item(OP_QUERY, key_t'(5 <<< 16), '0);
    send_item(OP_QUERY, key_t'((5 <<< 16) + 1), '0);
    send_item(OP_LOAD, key_t'(10 <<< 16), level_t'(3));
    send_item(OP_QUERY, key_t'(10 <<< 16), '0);
    send_item(OP_QUERY, key_t'((10 <<< 16) + 1), '0);
  endtask

  task automatic test_table_full();
    send_item(OP_CLEAR, '0, '0);
    repeat (MAX_LEVELS) send_item(OP_LOAD, pick_grid(), level_t'($urandom));
    send_item(OP_LOAD, key_t'(0), level_t'(32'h5555_aaaa));
    send_item(OP_QUERY, pick_grid(), '0);
    send_item(OP_CLEAR, '0, '0);
  endtask

  task automatic test_random_traffic();
    int sent;
    int r;
    bit no_idle;
    sent    = 0;
    no_idle = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 100 == 0) no_idle = ($urandom_range(3) == 0);
      r = $urandom_range(99);
      if (r < 2) begin
        send_item(OP_CLEAR, key_t'($urandom), level_t'($urandom));
        sent++;
      end else if (r < 4) begin
        send_item(OP_UNUSED, key_t'($urandom), level_t'($urandom));
      end else if (r < 48) begin
        send_item(OP_LOAD, pick_load_key(), level_t'($urandom));
        sent++;
      end else begin
        send_item(OP_QUERY, pick_query_key(), level_t'($urandom));
        sent++;
      end
      if (!no_idle) pause(pick_gap());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_and_unused();
    test_extremes();
    test_ties_and_midpoints();
    test_table_full();
    test_random_traffic();

    @(negedge clk);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (fault_count == 0) begin
      $display("PASS nearest_level_quantizer");
    end else begin
      $display("FAIL nearest_level_quantizer");
    end
    $finish;
  end

endmodule
